FILE: rtl/core/cpb_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
package cpb_pkg;

  localparam logic [7:0]  HdrByte0      = 8'hA5;
  localparam logic [7:0]  HdrByte1      = 8'h5A;
  localparam logic [15:0] CrcPoly       = 16'hA001;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] FrameOverhead = 16'd13;
  localparam int          CmdDepth      = 4;

  // Step numbers inside one command.
  localparam logic [3:0]  StepHdrLast   = 4'd10;
  localparam logic [3:0]  StepHdrCrcLo  = 4'd11;
  localparam logic [3:0]  StepHdrCrcHi  = 4'd12;
  localparam logic [3:0]  StepDataCrcLo = 4'd1;
  localparam logic [3:0]  StepDataCrcHi = 4'd2;

  typedef enum logic [1:0] {
    CmdStart,
    CmdData,
    CmdError
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        crc_after;  // frame closes after this command
    logic [7:0]  msg_type;
    logic [15:0] payload_length;
    logic [31:0] tick_stamp;
    logic [7:0]  data;
  } cmd_t;

  // Reflected CRC-16, polynomial 0xA001, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/crc16_framed_packet_builder.sv
// Top level of the CRC-16/MODBUS framed packet builder.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i / in_ready_o req_type, msg_type, payload_length,
//                                         tick_stamp, payload_byte
//   out      out  out_valid_o/out_ready_i out_byte, frame_end, run_last, seq_error
//
// One output byte per cycle from the byte sequencer, unless the output stalls;
// a start gives 11 bytes (13 with no payload), payload 1 (3 if last), error 1.
// Items are taken every cycle while the command queue has room (Depth entries).
// Reset clears the open frame, the queue, the sequencer and the CRC to 0xFFFF.
// A stalled output holds its register; the queue keeps accepting until full.
module crc16_framed_packet_builder
  import cpb_pkg::*;
#(
  parameter int Depth = CmdDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  msg_type_i,
  input  logic [15:0] payload_length_i,
  input  logic [31:0] tick_stamp_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        run_last_o,
  output logic        seq_error_o
);

  logic fifo_ready, fifo_valid, push, pop;
  cmd_t push_cmd, head_cmd;

  cpb_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .msg_type_i,
    .payload_length_i,
    .tick_stamp_i,
    .payload_byte_i,
    .fifo_ready_i (fifo_ready),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  cpb_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (fifo_ready),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .cmd_o   (head_cmd)
  );

  cpb_back u_back (
    .clk_i,
    .rst_ni,
    .fifo_valid_i (fifo_valid),
    .fifo_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .frame_end_o,
    .run_last_o,
    .seq_error_o
  );

endmodule

FILE: rtl/core/cpb_front.sv
// Front end: accepts items, tracks the open frame and turns items into commands.
module cpb_front
  import cpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  msg_type_i,
  input  logic [15:0] payload_length_i,
  input  logic [31:0] tick_stamp_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        fifo_ready_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  // A frame is open exactly while payload bytes are still expected.
  logic [15:0] bytes_left_q, bytes_left_d;

  assign in_ready_o = fifo_ready_i;
  assign push_o     = in_valid_i & fifo_ready_i;

  always_comb begin
    cmd_o                = '0;
    cmd_o.msg_type       = msg_type_i;
    cmd_o.payload_length = payload_length_i;
    cmd_o.tick_stamp     = tick_stamp_i;
    cmd_o.data           = payload_byte_i;
    bytes_left_d         = bytes_left_q;
    if (!req_type_i) begin
      cmd_o.kind      = CmdStart;
      cmd_o.crc_after = (payload_length_i == 16'd0);
      bytes_left_d    = payload_length_i;
    end else if (bytes_left_q == 16'd0) begin
      cmd_o.kind      = CmdError;
      cmd_o.crc_after = 1'b0;
    end else begin
      cmd_o.kind      = CmdData;
      cmd_o.crc_after = (bytes_left_q == 16'd1);
      bytes_left_d    = bytes_left_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
    end else if (push_o) begin
      bytes_left_q <= bytes_left_d;
    end
  end

endmodule

FILE: rtl/core/cpb_fifo.sv
// Small command queue between the front end and the byte sequencer.
module cpb_fifo
  import cpb_pkg::*;
#(
  parameter int Depth = CmdDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/cpb_back.sv
// Back end: walks each command byte by byte, folds bytes into the CRC, drives the output register.
module cpb_back
  import cpb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fifo_valid_i,
  input  cmd_t       fifo_cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       run_last_o,
  output logic       seq_error_o
);

  cmd_t        cur_q;
  logic        cur_valid_q;
  logic [3:0]  step_q;
  logic [15:0] crc_q, crc_d, crc_base;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        frame_end_q, run_last_q, seq_error_q;

  logic        emit, load;
  logic [7:0]  byte_sel;
  logic        is_data, is_crc_hi, is_last, is_err;
  logic [15:0] total_len;

  assign total_len = cur_q.payload_length + FrameOverhead;
  // A start restarts the CRC, which also drops an abandoned frame.
  assign crc_base  = (cur_q.kind == CmdStart && step_q == 4'd0) ? CrcInit : crc_q;

  always_comb begin
    byte_sel  = 8'h00;
    is_data   = 1'b0;
    is_crc_hi = 1'b0;
    is_last   = 1'b0;
    is_err    = 1'b0;
    unique case (cur_q.kind)
      CmdStart: begin
        is_data = (step_q <= StepHdrLast);
        is_last = cur_q.crc_after ? (step_q == StepHdrCrcHi) : (step_q == StepHdrLast);
        case (step_q)
          4'd0:         byte_sel = HdrByte0;
          4'd1:         byte_sel = HdrByte1;
          4'd2:         byte_sel = total_len[15:8];
          4'd3:         byte_sel = total_len[7:0];
          4'd4:         byte_sel = cur_q.msg_type;
          4'd5:         byte_sel = cur_q.payload_length[15:8];
          4'd6:         byte_sel = cur_q.payload_length[7:0];
          4'd7:         byte_sel = cur_q.tick_stamp[31:24];
          4'd8:         byte_sel = cur_q.tick_stamp[23:16];
          4'd9:         byte_sel = cur_q.tick_stamp[15:8];
          StepHdrLast:  byte_sel = cur_q.tick_stamp[7:0];
          StepHdrCrcLo: byte_sel = crc_q[7:0];
          default: begin
            byte_sel  = crc_q[15:8];
            is_crc_hi = 1'b1;
          end
        endcase
      end
      CmdData: begin
        is_data = (step_q == 4'd0);
        is_last = cur_q.crc_after ? (step_q == StepDataCrcHi) : (step_q == 4'd0);
        case (step_q)
          4'd0:          byte_sel = cur_q.data;
          StepDataCrcLo: byte_sel = crc_q[7:0];
          default: begin
            byte_sel  = crc_q[15:8];
            is_crc_hi = 1'b1;
          end
        endcase
      end
      default: begin
        is_last = 1'b1;
        is_err  = 1'b1;
      end
    endcase
  end

  assign emit  = cur_valid_q & (~out_valid_q | out_ready_i);
  assign load  = ~cur_valid_q | (emit & is_last);
  assign pop_o = load & fifo_valid_i;

  always_comb begin
    crc_d = crc_q;
    if (emit) begin
      if (is_data) begin
        crc_d = crc16_byte(crc_base, byte_sel);
      end else if (is_crc_hi) begin
        crc_d = CrcInit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= fifo_cmd_i;
    end
    if (emit) begin
      out_byte_q  <= byte_sel;
      frame_end_q <= is_crc_hi;
      run_last_q  <= is_last;
      seq_error_q <= is_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= '0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      crc_q <= crc_d;
      if (load) begin
        cur_valid_q <= fifo_valid_i;
        step_q      <= '0;
      end else if (emit) begin
        step_q <= step_q + 4'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;
  assign seq_error_o = seq_error_q;

endmodule

FILE: test/crc16_framed_packet_checker.sv
// Request codes and the scoreboard that predicts and checks the frame builder output.
`timescale 1ns / 100ps

package cpb_tb_pkg;
  localparam logic ReqStart   = 1'b0;
  localparam logic ReqPayload = 1'b1;
endpackage

module crc16_framed_packet_checker
  import cpb_pkg::*;
  import cpb_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        req_type_i,
  input  logic [7:0]  msg_type_i,
  input  logic [15:0] payload_length_i,
  input  logic [31:0] tick_stamp_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        frame_end_i,
  input  logic        run_last_i,
  input  logic        seq_error_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
    logic       seq_error;
  } frame_byte_t;

  frame_byte_t frame_bytes_q[$];

  // model of the frame state
  logic [15:0] crc_q;
  logic [15:0] bytes_remaining;
  logic        frame_active;

  // bytes caused by the item being predicted
  frame_byte_t staged[13];
  int          staged_n;

  // bit-serial form of the reflected CRC, data LSB first
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r  = {1'b0, r[15:1]} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic void stage_data(input logic [7:0] b);
    staged[staged_n] = '{data: b, frame_end: 1'b0, run_last: 1'b0, seq_error: 1'b0};
    staged_n++;
    crc_q = crc_next(crc_q, b);
  endfunction

  function automatic void stage_crc();
    staged[staged_n]     = '{data: crc_q[7:0], frame_end: 1'b0, run_last: 1'b0,
                             seq_error: 1'b0};
    staged[staged_n + 1] = '{data: crc_q[15:8], frame_end: 1'b1, run_last: 1'b0,
                             seq_error: 1'b0};
    staged_n += 2;
    crc_q           = CrcInit;
    frame_active    = 1'b0;
    bytes_remaining = '0;
  endfunction

  function automatic void predict_frame_bytes(input logic req, input logic [7:0] mtype,
                                              input logic [15:0] plen,
                                              input logic [31:0] ts,
                                              input logic [7:0] pb);
    logic [15:0] total;
    staged_n = 0;
    total    = plen + FrameOverhead;
    if (req == ReqStart) begin
      // a start always restarts the CRC, dropping any open frame
      crc_q           = CrcInit;
      frame_active    = 1'b1;
      bytes_remaining = plen;
      stage_data(HdrByte0);
      stage_data(HdrByte1);
      stage_data(total[15:8]);
      stage_data(total[7:0]);
      stage_data(mtype);
      stage_data(plen[15:8]);
      stage_data(plen[7:0]);
      stage_data(ts[31:24]);
      stage_data(ts[23:16]);
      stage_data(ts[15:8]);
      stage_data(ts[7:0]);
      if (bytes_remaining == 16'd0) stage_crc();
    end else if (!frame_active || bytes_remaining == 16'd0) begin
      // stray byte: single error item, state untouched
      staged[0] = '{data: 8'h00, frame_end: 1'b0, run_last: 1'b0, seq_error: 1'b1};
      staged_n  = 1;
    end else begin
      stage_data(pb);
      bytes_remaining--;
      if (bytes_remaining == 16'd0) stage_crc();
    end
    staged[staged_n - 1].run_last = 1'b1;
    for (int i = 0; i < staged_n; i++) frame_bytes_q.push_back(staged[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t want;
    if (!rst_ni) begin
      crc_q           = CrcInit;
      bytes_remaining = '0;
      frame_active    = 1'b0;
      frame_bytes_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        predict_frame_bytes(req_type_i, msg_type_i, payload_length_i, tick_stamp_i,
                            payload_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (frame_bytes_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("%0t: unexpected item: byte %02h end %b last %b err %b", $time,
                     out_byte_i, frame_end_i, run_last_i, seq_error_i);
          end
        end else begin
          want = frame_bytes_q.pop_front();
          checked_o++;
          if (want.data !== out_byte_i || want.frame_end !== frame_end_i ||
              want.run_last !== run_last_i || want.seq_error !== seq_error_i) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch: expected byte %02h end %b last %b err %b", $time,
                       want.data, want.frame_end, want.run_last, want.seq_error);
              $display("%0t:           got      byte %02h end %b last %b err %b", $time,
                       out_byte_i, frame_end_i, run_last_i, seq_error_i);
            end
          end
        end
      end
    end
    pending_o = frame_bytes_q.size();
  end

endmodule

FILE: test/crc16_framed_packet_builder_tb.sv
// Testbench top: clock, reset, request stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module crc16_framed_packet_builder_tb;
  import cpb_pkg::*;
  import cpb_tb_pkg::*;

  localparam int ClkPeriod  = 20;
  localparam int ItemTarget = 480;
  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  msg_type_i;
  logic [15:0] payload_length_i;
  logic [31:0] tick_stamp_i;
  logic [7:0]  payload_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic        run_last_o;
  logic        seq_error_o;

  int errors;
  int pending;
  int checked;
  int cycles;
  int items_sent;
  int frames_sent;
  int strays_sent;
  logic steady_run;

  crc16_framed_packet_builder i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .msg_type_i       (msg_type_i),
    .payload_length_i (payload_length_i),
    .tick_stamp_i     (tick_stamp_i),
    .payload_byte_i   (payload_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .frame_end_o      (frame_end_o),
    .run_last_o       (run_last_o),
    .seq_error_o      (seq_error_o)
  );

  crc16_framed_packet_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .msg_type_i       (msg_type_i),
    .payload_length_i (payload_length_i),
    .tick_stamp_i     (tick_stamp_i),
    .payload_byte_i   (payload_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_i       (out_byte_o),
    .frame_end_i      (frame_end_o),
    .run_last_i       (run_last_o),
    .seq_error_i      (seq_error_o),
    .errors_o         (errors),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // no idling on either side through a window of the random part
  assign steady_run = (items_sent >= 250 && items_sent < 330);

  always @(negedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d items still expected", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic req, input logic [7:0] mtype,
                           input logic [15:0] plen, input logic [31:0] ts,
                           input logic [7:0] pb);
    if (!steady_run && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    msg_type_i       <= mtype;
    payload_length_i <= plen;
    tick_stamp_i     <= ts;
    payload_byte_i   <= pb;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_start(input logic [7:0] mtype, input logic [15:0] plen,
                            input logic [31:0] ts);
    frames_sent++;
    send_item(ReqStart, mtype, plen, ts, 8'($urandom()));
  endtask

  task automatic send_byte(input logic [7:0] pb);
    send_item(ReqPayload, 8'($urandom()), 16'($urandom()), $urandom(), pb);
  endtask

  task automatic send_stray(input logic [7:0] pb);
    strays_sent++;
    send_byte(pb);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // mostly complete frames; some cut short by the next start, some followed by a stray
  task automatic send_random_frame();
    int r;
    int plen;
    int cut;
    r = $urandom_range(99);
    if (r < 10) plen = 0;
    else if (r < 85) plen = $urandom_range(8, 1);
    else if (r < 95) plen = $urandom_range(40, 9);
    else plen = $urandom_range(65535, 41);
    cut = plen;
    if (plen > 40) cut = $urandom_range(5, 0);
    else if (plen > 1 && $urandom_range(99) < 8) cut = $urandom_range(plen - 1, 1);
    send_start(8'($urandom_range(255)), 16'(plen), $urandom());
    for (int k = 0; k < cut; k++) send_byte(8'($urandom_range(255)));
    if (cut == plen && $urandom_range(99) < 8) send_stray(8'($urandom_range(255)));
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = ReqStart;
    msg_type_i       = '0;
    payload_length_i = '0;
    tick_stamp_i     = '0;
    payload_byte_i   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // stray bytes straight out of reset
    send_stray(8'h00);
    send_stray(8'hFF);
    // empty payloads: CRC right after the header
    send_start(8'h00, 16'h0000, 32'h0000_0000);
    send_start(8'hFF, 16'h0000, 32'hFFFF_FFFF);
    send_start(8'h3C, 16'd3, 32'h1234_5678);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_stray(8'h77);
    // oversize length wraps the total field; later starts abandon open frames
    send_start(8'h81, 16'hFFFF, 32'hDEAD_BEEF);
    send_byte(8'h5A);
    send_byte(8'hC3);
    send_start(8'h42, 16'd65522, 32'h8000_0001);
    send_byte(8'h11);
    send_start(8'h01, 16'd1, 32'h7FFF_FFFE);
    send_start(8'h02, 16'd2, 32'h0F0F_F0F0);
    send_byte(8'h96);
    send_byte(8'h69);
    send_stray(8'hAA);
    wait_drained();

    while (items_sent < ItemTarget) begin
      send_random_frame();
      if ($urandom_range(39) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("sent %0d items: %0d frame starts, %0d stray bytes", items_sent, frames_sent,
             strays_sent);
    $display("checked %0d output bytes, %0d failures", checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cpb_pkg.sv
rtl/core/cpb_front.sv
rtl/core/cpb_fifo.sv
rtl/core/cpb_back.sv
rtl/core/crc16_framed_packet_builder.sv
test/crc16_framed_packet_checker.sv
test/crc16_framed_packet_builder_tb.sv
